// File: rtl/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared codes and types for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int unsigned FIELD_W = 32;   // width of value fields on the ports
    localparam int unsigned COUNT_W = 7;    // width of entry_count on the port

    typedef enum logic [1:0] {
        KIND_PUSH_BACK  = 2'd0,
        KIND_PUSH_FRONT = 2'd1,
        KIND_POP_BACK   = 2'd2,
        KIND_POP_FRONT  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_DONE       = 2'd0,
        STATUS_POP_EMPTY  = 2'd1,
        STATUS_PUSH_FULL  = 2'd2
    } t_status;

    // Per-item result flags travelling from the pointer logic to the result stage
    typedef struct packed {
        t_status              status;
        logic                 is_empty;
        logic                 is_full;
        logic [COUNT_W-1:0]   entry_count;
        logic                 fwd_front;   // front slot written this cycle
        logic                 fwd_back;    // back slot written this cycle
    } t_res_info;

endpackage

// File: rtl/deq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_if
// Valid/ready channels for operations into and results out of the deque.
// ----------------------------------------------------------------------------
interface deq_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    kind;
    logic [deq_pkg::FIELD_W-1:0]   value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface deq_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [deq_pkg::FIELD_W-1:0]   front_value;
    logic [deq_pkg::FIELD_W-1:0]   back_value;
    logic                          is_empty;
    logic                          is_full;
    logic [deq_pkg::COUNT_W-1:0]   entry_count;

    modport source (output valid, output status, output front_value, output back_value,
                    output is_empty, output is_full, output entry_count, input ready);
    modport sink   (input valid, input status, input front_value, input back_value,
                    input is_empty, input is_full, input entry_count, output ready);
endinterface

// File: rtl/double_ended_queue_top.sv
`timescale 1ns / 1ps
// A result passes from its input transfer through the s1 stage register and then the
// output register; both hold it while the output is stalled.
// Throughput: one operation per cycle while the output is not stalled; a push uses
// the store's single write port, and each operation both read ports once, in the
// cycle it transfers in. Reset clears head index, fill count and both pipeline valids;
// the store is not cleared, and read data is only passed on from slots a push wrote.
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue over a circular slot store.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    deq_in_if.sink    i_in,
    deq_out_if.source o_out
);

    localparam int unsigned ADDR_W  = $clog2(DEPTH);
    localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
    // bits above the 32-bit port are always zero, so they are not stored
    localparam int unsigned STORE_W = (DATA_WIDTH < deq_pkg::FIELD_W) ? DATA_WIDTH
                                                                       : deq_pkg::FIELD_W;

    logic                       accept;
    logic                       s1_move;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_front;
    logic [ADDR_W-1:0]          rd_back;
    logic [STORE_W-1:0]         rd_front_data;
    logic [STORE_W-1:0]         rd_back_data;
    logic [STORE_W-1:0]         push_word;
    deq_pkg::t_res_info         info;

    logic                       r_s1_valid;
    deq_pkg::t_res_info         r_s1_info;
    logic [STORE_W-1:0]         r_s1_word;

    logic                       r_out_valid;
    logic [1:0]                 r_out_status;
    logic [deq_pkg::FIELD_W-1:0] r_out_front;
    logic [deq_pkg::FIELD_W-1:0] r_out_back;
    logic                       r_out_empty;
    logic                       r_out_full;
    logic [deq_pkg::COUNT_W-1:0] r_out_count;

    logic [STORE_W-1:0]         n_front;
    logic [STORE_W-1:0]         n_back;

    assign s1_move    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_move;
    assign accept     = i_in.valid && i_in.ready;
    assign push_word  = i_in.value[STORE_W-1:0];

    deq_ctrl #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_kind     (i_in.kind),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_rd_front (rd_front),
        .o_rd_back  (rd_back),
        .o_info     (info)
    );

    deq_mem #(
        .DEPTH  (DEPTH),
        .WIDTH  (STORE_W),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (push_word),
        .i_rd_en     (accept),
        .i_rd_addr_a (rd_front),
        .i_rd_addr_b (rd_back),
        .o_rd_data_a (rd_front_data),
        .o_rd_data_b (rd_back_data)
    );

    // the word pushed in the same transfer is not yet visible in the read data
    assign n_front = r_s1_info.fwd_front ? r_s1_word : rd_front_data;
    assign n_back  = r_s1_info.fwd_back  ? r_s1_word : rd_back_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_info <= info;
            r_s1_word <= push_word;
        end
        if (s1_move) begin
            r_out_status <= r_s1_info.status;
            r_out_empty  <= r_s1_info.is_empty;
            r_out_full   <= r_s1_info.is_full;
            r_out_count  <= r_s1_info.entry_count;
            r_out_front  <= r_s1_info.is_empty ? '0 : deq_pkg::FIELD_W'(n_front);
            r_out_back   <= r_s1_info.is_empty ? '0 : deq_pkg::FIELD_W'(n_back);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.front_value = r_out_front;
    assign o_out.back_value  = r_out_back;
    assign o_out.is_empty    = r_out_empty;
    assign o_out.is_full     = r_out_full;
    assign o_out.entry_count = r_out_count;

`ifndef SYNTHESIS
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |-> !accept)
        else $error("double_ended_queue_top: transfer overwrote a waiting item");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |-> (r_out_front == '0 && r_out_back == '0
                                          && r_out_count == '0))
        else $error("double_ended_queue_top: empty result carries data");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_full && r_out_empty))
        else $error("double_ended_queue_top: result both full and empty");
`endif

endmodule

// File: rtl/deq_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_mem
// Slot store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module deq_mem #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned WIDTH  = 32,
    parameter int unsigned ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr_a,
    input  logic [ADDR_W-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]  o_rd_data_a,
    output logic [WIDTH-1:0]  o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    // read-before-write on a same-address collision; caller forwards
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// File: rtl/deq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Head index and fill count; decides status, write slot and read slots.
// ----------------------------------------------------------------------------
module deq_ctrl #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6,
    parameter int unsigned CNT_W  = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [1:0]           i_kind,
    output logic                 o_wr_en,
    output logic [ADDR_W-1:0]    o_wr_addr,
    output logic [ADDR_W-1:0]    o_rd_front,
    output logic [ADDR_W-1:0]    o_rd_back,
    output deq_pkg::t_res_info   o_info
);

    localparam logic [ADDR_W:0]   DEPTH_SUM = (ADDR_W+1)'(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

    logic [ADDR_W-1:0] r_head;
    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] n_head;
    logic [CNT_W-1:0]  n_count;

    deq_pkg::t_kind    kind;
    deq_pkg::t_status  status;
    logic              is_push;
    logic              full;
    logic              empty;
    logic [ADDR_W:0]   tail_sum;
    logic [ADDR_W-1:0] tail_addr;
    logic [ADDR_W:0]   back_sum;
    logic [ADDR_W-1:0] back_addr;

    assign kind    = deq_pkg::t_kind'(i_kind);
    assign is_push = ~i_kind[1];
    assign full    = (r_count == FULL_CNT);
    assign empty   = (r_count == '0);

    // slot one past the back entry (only used when not full)
    assign tail_sum  = {1'b0, r_head} + {1'b0, ADDR_W'(r_count)};
    assign tail_addr = (tail_sum >= DEPTH_SUM) ? ADDR_W'(tail_sum - DEPTH_SUM)
                                               : tail_sum[ADDR_W-1:0];

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        o_wr_en = 1'b0;
        o_wr_addr = tail_addr;
        if (is_push && full) begin
            status = deq_pkg::STATUS_PUSH_FULL;
        end else if (!is_push && empty) begin
            status = deq_pkg::STATUS_POP_EMPTY;
        end else begin
            status = deq_pkg::STATUS_DONE;
            case (kind)
                deq_pkg::KIND_PUSH_BACK: begin
                    o_wr_en = i_accept;
                    o_wr_addr = tail_addr;
                    n_count = r_count + CNT_W'(1);
                end
                deq_pkg::KIND_PUSH_FRONT: begin
                    n_head = (r_head == '0) ? LAST_IDX : r_head - ADDR_W'(1);
                    o_wr_en = i_accept;
                    o_wr_addr = n_head;
                    n_count = r_count + CNT_W'(1);
                end
                deq_pkg::KIND_POP_BACK: begin
                    n_count = r_count - CNT_W'(1);
                end
                deq_pkg::KIND_POP_FRONT: begin
                    n_head = (r_head == LAST_IDX) ? '0 : r_head + ADDR_W'(1);
                    n_count = r_count - CNT_W'(1);
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    // back entry after the operation; don't care when the deque ends up empty
    assign back_sum  = {1'b0, n_head} + {1'b0, ADDR_W'(n_count - CNT_W'(1))};
    assign back_addr = (back_sum >= DEPTH_SUM) ? ADDR_W'(back_sum - DEPTH_SUM)
                                               : back_sum[ADDR_W-1:0];

    assign o_rd_front = n_head;
    assign o_rd_back  = back_addr;

    always_comb begin
        o_info.status      = status;
        o_info.is_empty    = (n_count == '0);
        o_info.is_full     = (n_count == FULL_CNT);
        o_info.entry_count = deq_pkg::COUNT_W'(n_count);
        o_info.fwd_front   = o_wr_en && (o_wr_addr == n_head);
        o_info.fwd_back    = o_wr_en && (o_wr_addr == back_addr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("deq_ctrl: fill count beyond depth");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && status != deq_pkg::STATUS_DONE) |=> ($stable(r_head) && $stable(r_count)))
        else $error("deq_ctrl: rejected operation changed state");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && is_push && status == deq_pkg::STATUS_DONE)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("deq_ctrl: push did not add one entry");

    a_write_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (i_accept && is_push && !full))
        else $error("deq_ctrl: store written without an accepted push");
`endif

endmodule

// File: verif/tb_double_ended_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_top
// Self-checking bench for the double-ended queue. A short table of directed
// operations (empty pops, extreme data words, wrap of the head index) is
// followed by random traffic in fill, drain and mixed segments, so the deque
// hits full and empty many times. Each result transfer is checked field by field
// against an in-bench deque model or a typed row; both channels idle at random.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_top;

    localparam int unsigned DEPTH       = 64;
    localparam int unsigned DATA_WIDTH  = 32;
    localparam int unsigned IDX_W       = $clog2(DEPTH);
    localparam int unsigned RAND_OPS    = 532;
    localparam int unsigned CALM_OPS    = 60;    // closing stretch without idling
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned N_DIRECTED  = 18;
    localparam int unsigned N_OPS       = N_DIRECTED + RAND_OPS;

    typedef struct packed {
        deq_pkg::t_status                status;
        logic [deq_pkg::FIELD_W-1:0]     front;
        logic [deq_pkg::FIELD_W-1:0]     back;
        logic                            empty;
        logic                            full;
        logic [deq_pkg::COUNT_W-1:0]     count;
    } t_deq_result;

    typedef struct packed {
        deq_pkg::t_kind                  kind;
        logic [deq_pkg::FIELD_W-1:0]     value;
        logic                            typed;     // use the result written below
        t_deq_result                     want;
    } t_dir_row;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } t_traffic;

    localparam t_deq_result EMPTY_REJECT =
        '{deq_pkg::STATUS_POP_EMPTY, '0, '0, 1'b1, 1'b0, 7'd0};
    localparam t_deq_result NOW_EMPTY    =
        '{deq_pkg::STATUS_DONE, '0, '0, 1'b1, 1'b0, 7'd0};
    localparam t_deq_result NOT_TYPED    =
        '{deq_pkg::STATUS_DONE, '0, '0, 1'b0, 1'b0, 7'd0};

    t_dir_row dir_rows [N_DIRECTED] = '{
        '{deq_pkg::KIND_POP_BACK,   32'h0000_0000, 1'b1, EMPTY_REJECT},
        '{deq_pkg::KIND_POP_FRONT,  32'hFFFF_FFFF, 1'b1, EMPTY_REJECT},
        '{deq_pkg::KIND_PUSH_BACK,  32'hFFFF_FFFF, 1'b1,
          '{deq_pkg::STATUS_DONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 7'd1}},
        '{deq_pkg::KIND_PUSH_FRONT, 32'h0000_0000, 1'b1,
          '{deq_pkg::STATUS_DONE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 7'd2}},
        '{deq_pkg::KIND_PUSH_BACK,  32'hA5A5_A5A5, 1'b0, NOT_TYPED},
        '{deq_pkg::KIND_PUSH_FRONT, 32'h5A5A_5A5A, 1'b0, NOT_TYPED},
        '{deq_pkg::KIND_POP_BACK,   32'h0000_0000, 1'b0, NOT_TYPED},
        '{deq_pkg::KIND_POP_FRONT,  32'h0000_0000, 1'b0, NOT_TYPED},
        '{deq_pkg::KIND_POP_FRONT,  32'h0000_0000, 1'b0, NOT_TYPED},
        '{deq_pkg::KIND_POP_BACK,   32'h0000_0000, 1'b1, NOW_EMPTY},
        '{deq_pkg::KIND_POP_FRONT,  32'h0000_0000, 1'b1, EMPTY_REJECT},
        '{deq_pkg::KIND_PUSH_FRONT, 32'h8000_0000, 1'b0, NOT_TYPED},
        '{deq_pkg::KIND_PUSH_FRONT, 32'h0000_0001, 1'b0, NOT_TYPED},
        '{deq_pkg::KIND_PUSH_BACK,  32'h7FFF_FFFF, 1'b0, NOT_TYPED},
        '{deq_pkg::KIND_POP_FRONT,  32'hFFFF_FFFF, 1'b0, NOT_TYPED},
        '{deq_pkg::KIND_POP_BACK,   32'h5555_AAAA, 1'b0, NOT_TYPED},
        '{deq_pkg::KIND_POP_BACK,   32'hAAAA_5555, 1'b1, NOW_EMPTY},
        '{deq_pkg::KIND_PUSH_BACK,  32'h1234_5678, 1'b0, NOT_TYPED}
    };

    logic clk = 1'b0;
    logic rst_n;

    deq_in_if  in_ch ();
    deq_out_if out_ch ();

    double_ended_queue_top #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Deque model state
    logic [deq_pkg::FIELD_W-1:0] slot_mem [DEPTH];
    logic [IDX_W-1:0]            head_idx;
    logic [deq_pkg::COUNT_W-1:0] fill;

    // Expected results in transfer order; written by the driver, read by the monitor
    t_deq_result exp_mem [N_OPS];
    int unsigned exp_wr = 0;
    int unsigned exp_rd = 0;

    int unsigned cycles = 0;
    int unsigned ops_sent;
    int unsigned results_seen = 0;
    int unsigned full_rejects;
    int unsigned empty_rejects;
    int unsigned errors = 0;
    bit          calm;
    int unsigned stall_left = 0;

    always #4 clk = ~clk;

    // Applies one operation to the model deque and returns what it reports
    function automatic t_deq_result apply_op(deq_pkg::t_kind kind,
                                             logic [deq_pkg::FIELD_W-1:0] value);
        t_deq_result r;
        logic [IDX_W-1:0] back_idx;
        r = NOT_TYPED;
        r.status = deq_pkg::STATUS_DONE;
        if (kind == deq_pkg::KIND_PUSH_BACK || kind == deq_pkg::KIND_PUSH_FRONT) begin
            if (fill == DEPTH) begin
                r.status = deq_pkg::STATUS_PUSH_FULL;
            end else if (kind == deq_pkg::KIND_PUSH_BACK) begin
                slot_mem[IDX_W'(head_idx + fill)] = value;
                fill = fill + 1'b1;
            end else begin
                head_idx = head_idx - 1'b1;
                slot_mem[head_idx] = value;
                fill = fill + 1'b1;
            end
        end else begin
            if (fill == 0) begin
                r.status = deq_pkg::STATUS_POP_EMPTY;
            end else if (kind == deq_pkg::KIND_POP_BACK) begin
                fill = fill - 1'b1;
            end else begin
                head_idx = head_idx + 1'b1;
                fill = fill - 1'b1;
            end
        end
        if (fill != 0) begin
            back_idx = IDX_W'(head_idx + fill - 1'b1);
            r.front  = slot_mem[head_idx];
            r.back   = slot_mem[back_idx];
        end
        r.empty = (fill == 0);
        r.full  = (fill == DEPTH);
        r.count = fill;
        return r;
    endfunction

    function automatic void flag_error(string what);
        errors++;
        if (errors <= 10)
            $display("[%0t] ERROR: %s", $time, what);
    endfunction

    // Drive one operation and hold it until it transfers in
    task automatic send_op(deq_pkg::t_kind kind, logic [deq_pkg::FIELD_W-1:0] value,
                           bit typed, t_deq_result want);
        t_deq_result r;
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind  <= kind;
        in_ch.value <= value;
        do @(posedge clk); while (!in_ch.ready);
        r = apply_op(kind, value);
        if (r.status == deq_pkg::STATUS_PUSH_FULL)
            full_rejects++;
        if (r.status == deq_pkg::STATUS_POP_EMPTY)
            empty_rejects++;
        exp_mem[exp_wr] = typed ? want : r;
        exp_wr++;
        ops_sent++;
        calm = (ops_sent >= N_DIRECTED + RAND_OPS - CALM_OPS);
        @(negedge clk);
    endtask

    function automatic deq_pkg::t_kind pick_kind(t_traffic mode);
        int unsigned push_pct;
        bit          side;
        case (mode)
            MODE_FILL:  push_pct = 90;
            MODE_DRAIN: push_pct = 10;
            default:    push_pct = 50;
        endcase
        side = $urandom_range(0, 1);
        if ($urandom_range(0, 99) < push_pct)
            return side ? deq_pkg::KIND_PUSH_FRONT : deq_pkg::KIND_PUSH_BACK;
        return side ? deq_pkg::KIND_POP_FRONT : deq_pkg::KIND_POP_BACK;
    endfunction

    function automatic logic [deq_pkg::FIELD_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Result side: random stall bursts, none in the closing stretch
    always @(negedge clk) begin
        if (stall_left != 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else if (!calm && rst_n && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        t_deq_result want;
        string       exp_s;
        string       got_s;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (exp_rd == exp_wr) begin
                flag_error("result transfer with no operation outstanding");
            end else begin
                want = exp_mem[exp_rd];
                exp_rd++;
                if (out_ch.status !== want.status || out_ch.is_empty !== want.empty
                    || out_ch.is_full !== want.full || out_ch.entry_count !== want.count
                    || out_ch.front_value !== want.front
                    || out_ch.back_value !== want.back) begin
                    exp_s = $sformatf("st=%0d f=%h b=%h e=%b fu=%b n=%0d",
                                      want.status, want.front, want.back, want.empty,
                                      want.full, want.count);
                    got_s = $sformatf("st=%0d f=%h b=%h e=%b fu=%b n=%0d",
                                      out_ch.status, out_ch.front_value,
                                      out_ch.back_value, out_ch.is_empty,
                                      out_ch.is_full, out_ch.entry_count);
                    flag_error($sformatf("result %0d: exp %s, got %s",
                                         results_seen, exp_s, got_s));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results outstanding",
                     cycles, exp_wr - exp_rd);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_traffic    mode;
        int unsigned seg_len;
        int unsigned rand_done;
        int unsigned seg_no;

        ops_sent      = 0;
        full_rejects  = 0;
        empty_rejects = 0;
        calm          = 1'b0;
        head_idx      = '0;
        fill          = '0;
        foreach (slot_mem[i]) slot_mem[i] = '0;

        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.kind   = deq_pkg::KIND_PUSH_BACK;
        in_ch.value  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_op(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);

        // Open with a fill then a drain segment so the deque is driven toward full and empty early
        rand_done = 0;
        seg_no    = 0;
        while (rand_done < RAND_OPS) begin
            if (seg_no == 0)
                mode = MODE_FILL;
            else if (seg_no == 1)
                mode = MODE_DRAIN;
            else
                mode = t_traffic'($urandom_range(0, 2));
            seg_len = $urandom_range(30, 110);
            for (int unsigned j = 0; j < seg_len && rand_done < RAND_OPS; j++) begin
                send_op(pick_kind(mode), pick_value(), 1'b0, NOT_TYPED);
                rand_done++;
            end
            seg_no++;
        end
        in_ch.valid <= 1'b0;

        while (exp_rd != exp_wr) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Ran %0d operations in %0d traffic segments; %0d results checked.",
                 ops_sent, seg_no, results_seen);
        $display("Rejections seen: %0d pushes on a full deque, %0d pops on an empty one.",
                 full_rejects, empty_rejects);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d errors", errors);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: double_ended_queue_top.f
rtl/deq_pkg.sv
rtl/deq_if.sv
rtl/deq_mem.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue_top.sv
verif/tb_double_ended_queue_top.sv
